// ===== design/asrd_pkg.sv =====
// Shared types and constants for the screen rotation detector.
`default_nettype none
package asrd_pkg;

  // Phase codes of the rotation tracker
  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_ROTATING = 2'd1;
  localparam logic [1:0] PH_ROTATED  = 2'd2;

  // Orientation codes; bit 2 set means no orientation is known yet
  localparam logic [2:0] ORIENT_V90   = 3'd0;
  localparam logic [2:0] ORIENT_H0    = 3'd1;
  localparam logic [2:0] ORIENT_V270  = 3'd2;
  localparam logic [2:0] ORIENT_H180  = 3'd3;
  localparam logic [2:0] ORIENT_NONE  = 3'd4;

  // Register indexes (byte address divided by four)
  localparam logic [1:0] REG_VALID_LIMIT  = 2'd0;
  localparam logic [1:0] REG_BAND_LOW_SQ  = 2'd1;
  localparam logic [1:0] REG_BAND_HIGH_SQ = 2'd2;

  localparam logic [15:0] VALID_LIMIT_RST  = 16'h8000;
  localparam logic [31:0] BAND_LOW_SQ_RST  = 32'd0;
  localparam logic [31:0] BAND_HIGH_SQ_RST = 32'hC000_0000;

  typedef struct packed {
    logic [15:0] valid_limit;
    logic [31:0] band_low_sq;
    logic [31:0] band_high_sq;
  } cfg_t;

  typedef struct packed {
    logic [1:0] phase_next;
    logic [2:0] orient_next;
    logic       emit;
  } eval_t;

endpackage
`default_nettype wire

// ===== design/accel_screen_rotation_detector_top.sv =====
// Top level of the accelerometer screen rotation detector.
`default_nettype none
// Takes accelerometer samples on the s_ stream and reports a new screen orientation
// on the m_ stream each time the device settles in a pose. One item is accepted every
// clock cycle when the output side keeps up; a result passes through the input register,
// one combinational pass with three 17x17 squarings and the band and tilt compares, and
// then the result register. Items that cause no result are consumed without any output.
// Registers are written through the APB port; the user must change them only while no
// items are in flight, and the block itself does not enforce this.
module accel_screen_rotation_detector_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // raw_x [15:0], raw_y [31:16], raw_z [47:32]
  input  wire logic        s_tuser,   // is_accel [0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // orientation_code [1:0], zero [7:2]
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import asrd_pkg::*;

  cfg_t        cfg;
  eval_t       ev;

  logic        in_valid;
  logic        in_is_accel;
  logic [15:0] in_x, in_y, in_z;
  logic        advance;

  logic [1:0]  phase;
  logic [2:0]  last_orientation;
  logic [1:0]  code;

  asrd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  asrd_eval u_eval (
    .cfg              (cfg),
    .is_accel         (in_is_accel),
    .raw_x            (in_x),
    .raw_y            (in_y),
    .raw_z            (in_z),
    .phase            (phase),
    .last_orientation (last_orientation),
    .ev               (ev)
  );

  // The held item moves on whenever the result register is free or being emptied.
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_is_accel <= s_tuser;
      in_x        <= s_tdata[15:0];
      in_y        <= s_tdata[31:16];
      in_z        <= s_tdata[47:32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      last_orientation <= ORIENT_NONE;
    end else if (advance) begin
      phase            <= ev.phase_next;
      last_orientation <= ev.orient_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= ev.emit;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && ev.emit) begin
      code <= ev.orient_next[1:0];
    end
  end

  assign m_tdata = {6'd0, code};

`ifndef ASSERT_OFF
  // A report is only made on entering the rotated phase with a known orientation.
  a_emit_rotated: assert property (@(posedge clk) disable iff (rst)
    (advance && ev.emit) |=> (phase == PH_ROTATED && !last_orientation[2]
                              && code == last_orientation[1:0]))
    else $error("result issued without a settled orientation");

  // While a result is stalled, no item may be evaluated.
  a_stall_holds_state: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> ($stable(phase) && $stable(last_orientation)))
    else $error("state changed while the result register was stalled");

  // A held item that cannot advance stays held.
  a_input_held: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> in_valid)
    else $error("held item lost");
`endif

endmodule
`default_nettype wire

// ===== design/asrd_regs.sv =====
// Configuration register file with an APB-style access port.
`default_nettype none
module asrd_regs (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [3:0]     paddr,
  input  wire logic [31:0]    pwdata,
  output logic      [31:0]    prdata,
  output logic                pready,
  output asrd_pkg::cfg_t      cfg
);
  import asrd_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.valid_limit  <= VALID_LIMIT_RST;
      cfg.band_low_sq  <= BAND_LOW_SQ_RST;
      cfg.band_high_sq <= BAND_HIGH_SQ_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_VALID_LIMIT:  cfg.valid_limit  <= pwdata[15:0];
        REG_BAND_LOW_SQ:  cfg.band_low_sq  <= pwdata;
        REG_BAND_HIGH_SQ: cfg.band_high_sq <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_VALID_LIMIT:  prdata = {16'd0, cfg.valid_limit};
      REG_BAND_LOW_SQ:  prdata = cfg.band_low_sq;
      REG_BAND_HIGH_SQ: prdata = cfg.band_high_sq;
      default:          prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/asrd_eval.sv =====
// Single-pass evaluation of one sample: squares, band and tilt tests, next phase.
`default_nettype none
module asrd_eval (
  input  wire asrd_pkg::cfg_t        cfg,
  input  wire logic                  is_accel,
  input  wire logic signed [15:0]    raw_x,
  input  wire logic signed [15:0]    raw_y,
  input  wire logic signed [15:0]    raw_z,
  input  wire logic        [1:0]     phase,
  input  wire logic        [2:0]     last_orientation,
  output asrd_pkg::eval_t            ev
);
  import asrd_pkg::*;

  logic [16:0] mag_x, mag_y, mag_z;
  logic [16:0] limit;
  logic        counts;
  logic [31:0] sq_x, sq_y, sq_z;
  logic [32:0] mag_sq;
  logic [33:0] plane4;
  logic        tilt, in_band, out_band;
  logic [2:0]  orient_cls;

  // Magnitudes need 17 bits so that -32768 is represented
  assign mag_x = raw_x[15] ? 17'(-{raw_x[15], raw_x}) : {1'b0, raw_x};
  assign mag_y = raw_y[15] ? 17'(-{raw_y[15], raw_y}) : {1'b0, raw_y};
  assign mag_z = raw_z[15] ? 17'(-{raw_z[15], raw_z}) : {1'b0, raw_z};

  assign limit  = {1'b0, cfg.valid_limit};
  assign counts = is_accel && (mag_x < limit) && (mag_y < limit) && (mag_z < limit);

  assign sq_x = {15'd0, mag_x} * {15'd0, mag_x};
  assign sq_y = {15'd0, mag_y} * {15'd0, mag_y};
  assign sq_z = {15'd0, mag_z} * {15'd0, mag_z};

  assign mag_sq   = 33'(sq_x) + 33'(sq_y) + 33'(sq_z);
  assign plane4   = {34'(sq_x) + 34'(sq_y)} << 2;
  assign tilt     = plane4 >= 34'(sq_z);
  assign in_band  = (mag_sq > 33'(cfg.band_low_sq)) && (mag_sq < 33'(cfg.band_high_sq));
  assign out_band = (mag_sq < 33'(cfg.band_low_sq)) || (mag_sq > 33'(cfg.band_high_sq));

  // Dominant in-plane axis; on an exact tie the previous orientation stands
  always_comb begin
    if (mag_x > mag_y) begin
      orient_cls = raw_x[15] ? ORIENT_V270 : ORIENT_V90;
    end else if (mag_y > mag_x) begin
      orient_cls = raw_y[15] ? ORIENT_H180 : ORIENT_H0;
    end else begin
      orient_cls = last_orientation;
    end
  end

  always_comb begin
    ev.phase_next  = phase;
    ev.orient_next = last_orientation;
    ev.emit        = 1'b0;
    if (counts) begin
      case (phase)
        PH_ROTATING: begin
          if (in_band) begin
            if (tilt) begin
              ev.phase_next  = PH_ROTATED;
              ev.orient_next = orient_cls;
              ev.emit        = !orient_cls[2];
            end else begin
              ev.phase_next = PH_IDLE;
            end
          end
        end
        PH_ROTATED: begin
          if (out_band) ev.phase_next = PH_ROTATING;
        end
        default: begin
          if (tilt) ev.phase_next = PH_ROTATING;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
